// ===== rtl/tts_pkg.sv =====
// Shared types and constants of the tone table sequencer.
package tts_pkg;

    localparam int OPCODE_W   = 2;
    localparam int ELAPSED_W  = 16;
    localparam int ADDR_W     = 8;
    localparam int CODE_W     = 8;
    localparam int ACTION_W   = 2;
    localparam int FREQ_W     = 12;
    localparam int INTERVAL_W = 24;
    localparam int REPEAT_W   = 8;
    localparam int LEN_W      = 9;
    localparam int ACC_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam int ADDR_RANGE = 2 ** ADDR_W;
    localparam int LEN_MAX    = 2 ** LEN_W - 1;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10000);
    localparam logic [REPEAT_W-1:0]   REPEAT_RESET   = REPEAT_W'(1);
    localparam logic [LEN_W-1:0]      LEN_RESET      = LEN_W'(180);

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_PLAY  = 2'd1,
        OP_WRITE = 2'd2
    } opcode_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE = 2'd0,
        ACT_PLAY = 2'd1,
        ACT_STOP = 2'd2
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INTERVAL = 2'd0,
        CFG_REPEAT   = 2'd1,
        CFG_LENGTH   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [ELAPSED_W-1:0]  elapsed_time;
        logic [ADDR_W-1:0]     entry_address;
        logic [CODE_W-1:0]     entry_value;
    } item_t;

    typedef struct packed {
        action_t               action;
        logic [FREQ_W-1:0]     frequency;
        logic                  playing;
    } result_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval_time;
        logic [REPEAT_W-1:0]   repeat_count;
        logic [LEN_W-1:0]      sequence_length;
    } cfg_t;

endpackage

// ===== rtl/tts_table.sv =====
// Tone table memory: one write port, one registered read port with write bypass.
module tts_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                              aclk,
    input  logic                                              wr_en,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] wr_addr,
    input  logic [tts_pkg::CODE_W-1:0]                        wr_data,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
    output logic [tts_pkg::CODE_W-1:0]                        rd_data
);
    import tts_pkg::*;

    logic [CODE_W-1:0] mem [TABLE_DEPTH];
    logic [CODE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // a word written in this cycle must be seen by the next tick
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/tts_ctrl.sv =====
// Sequencer state and the per-word step: timer, position, pass count.
module tts_ctrl #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              proc,
    input  tts_pkg::item_t                                    item,
    input  tts_pkg::cfg_t                                     cfg,
    input  logic [tts_pkg::CODE_W-1:0]                        rd_data,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_addr,
    output tts_pkg::result_t                                  res
);
    import tts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LEN_CAP = (TABLE_DEPTH > LEN_MAX) ? LEN_MAX : TABLE_DEPTH;

    logic              active_reg, active_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [REPEAT_W-1:0] pass_reg, pass_next;

    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  acc_sat;
    logic [LEN_W-1:0]  eff_len;
    logic [REPEAT_W:0] pass_inc;
    logic [FREQ_W-1:0] code_ext;

    always_comb begin
        sum      = {1'b0, acc_reg} + {{(ACC_W + 1 - ELAPSED_W){1'b0}}, item.elapsed_time};
        acc_sat  = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
        eff_len  = (cfg.sequence_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                            : cfg.sequence_length;
        pass_inc = {1'b0, pass_reg} + {{REPEAT_W{1'b0}}, 1'b1};
        code_ext = {{(FREQ_W - CODE_W){1'b0}}, rd_data};

        active_next  = active_reg;
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        pass_next    = pass_reg;
        res.action    = ACT_NONE;
        res.frequency = '0;

        if (proc) begin
            case (item.opcode)
                OP_TICK: begin
                    if (active_reg) begin
                        acc_next = acc_sat;
                        if (acc_sat > {{(ACC_W - INTERVAL_W){1'b0}}, cfg.interval_time}) begin
                            if (pos_reg < eff_len) begin
                                if (rd_data != '0) begin
                                    res.action    = ACT_PLAY;
                                    res.frequency = (code_ext << 3) + (code_ext << 1);
                                end else begin
                                    res.action = ACT_STOP;
                                end
                                pos_next = pos_reg + LEN_W'(1);
                                acc_next = '0;
                            end else begin
                                // end of pass: timer keeps running into the next pass
                                res.action = ACT_STOP;
                                pos_next   = '0;
                                if (pass_inc < {1'b0, cfg.repeat_count}) begin
                                    pass_next = pass_inc[REPEAT_W-1:0];
                                end else begin
                                    active_next = 1'b0;
                                    pass_next   = '0;
                                end
                            end
                        end
                    end
                end
                OP_PLAY: begin
                    active_next = 1'b1;
                    acc_next    = '0;
                    pos_next    = '0;
                    pass_next   = '0;
                end
                default: begin
                end
            endcase
        end

        res.playing = active_next;
    end

    // position is below the table depth whenever the read data is used
    assign rd_addr = AW'(pos_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            acc_reg    <= '0;
            pos_reg    <= '0;
            pass_reg   <= '0;
        end else begin
            active_reg <= active_next;
            acc_reg    <= acc_next;
            pos_reg    <= pos_next;
            pass_reg   <= pass_next;
        end
    end

    a_play_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && (item.opcode == OP_PLAY) |=>
            active_reg && (acc_reg == '0) && (pos_reg == '0) && (pass_reg == '0))
        else $error("play word did not restart the sequence");

    a_idle_tick_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && (item.opcode == OP_TICK) && !active_reg |-> (res.action == ACT_NONE))
        else $error("tick while idle produced an action");

    a_freq_only_on_play: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.action != ACT_PLAY) |-> (res.frequency == '0))
        else $error("frequency set without a play action");

    a_play_clears_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && (res.action == ACT_PLAY) |=> (acc_reg == '0))
        else $error("timer not cleared after emitting an entry");

    a_hold_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !proc |=> $stable(pos_reg) && $stable(acc_reg) && $stable(active_reg))
        else $error("sequencer state moved without a word");

endmodule

// ===== rtl/tone_table_sequencer_unit.sv =====
// Tone table sequencer: input register, step logic with table, result register.
//
// Accepts one word per clock while the result register is free or being read, and returns
// exactly one result word per input word; each word passes through the input register
// and then the result register. Between the two registers lies a combinational step:
// a saturating 32-bit timer add and compare against interval_time, plus a read of
// the tone table, which has one registered read port addressed by the position the
// previous word leaves behind (with bypass of a table write from that word). The
// table holds TABLE_DEPTH entries and has no reset; entries must be written before
// playback reaches them. Configuration writes take effect at once and are meant for
// times when no word is in flight.
module tone_table_sequencer_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tts_pkg::OPCODE_W-1:0]      s_opcode,
    input  logic [tts_pkg::ELAPSED_W-1:0]     s_elapsed_time,
    input  logic [tts_pkg::ADDR_W-1:0]        s_entry_address,
    input  logic [tts_pkg::CODE_W-1:0]        s_entry_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tts_pkg::ACTION_W-1:0]      m_action,
    output logic [tts_pkg::FREQ_W-1:0]        m_frequency,
    output logic                              m_playing,

    input  logic                              cfg_wr_en,
    input  logic [tts_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [tts_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import tts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef logic [AW-1:0] wrap_lut_t [ADDR_RANGE];

    // entry address modulo table depth, built by counting
    function automatic wrap_lut_t build_wrap_lut();
        wrap_lut_t   lut;
        int unsigned w;
        w = 0;
        for (int i = 0; i < ADDR_RANGE; i++) begin
            lut[i] = AW'(w);
            if (w == TABLE_DEPTH - 1) begin
                w = 0;
            end else begin
                w = w + 1;
            end
        end
        return lut;
    endfunction

    localparam wrap_lut_t WRAP_LUT = build_wrap_lut();

    logic     in_valid_reg;
    item_t    item_reg;
    logic     out_valid_reg;
    result_t  res_reg;
    cfg_t     cfg_reg;

    logic     proc;
    result_t  res;
    logic     tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    logic [AW-1:0] tbl_rd_addr;
    logic [CODE_W-1:0] tbl_rd_data;

    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            item_reg.opcode        <= opcode_t'(s_opcode);
            item_reg.elapsed_time  <= s_elapsed_time;
            item_reg.entry_address <= s_entry_address;
            item_reg.entry_value   <= s_entry_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc) begin
            res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.interval_time   <= INTERVAL_RESET;
            cfg_reg.repeat_count    <= REPEAT_RESET;
            cfg_reg.sequence_length <= LEN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_INTERVAL: cfg_reg.interval_time   <= cfg_wr_data[INTERVAL_W-1:0];
                CFG_REPEAT:   cfg_reg.repeat_count    <= cfg_wr_data[REPEAT_W-1:0];
                CFG_LENGTH:   cfg_reg.sequence_length <= cfg_wr_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign tbl_wr_en   = proc && (item_reg.opcode == OP_WRITE);
    assign tbl_wr_addr = WRAP_LUT[item_reg.entry_address];

    tts_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (item_reg.entry_value),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    tts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (proc),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .rd_data (tbl_rd_data),
        .rd_addr (tbl_rd_addr),
        .res     (res)
    );

    assign m_valid     = out_valid_reg;
    assign m_action    = res_reg.action;
    assign m_frequency = res_reg.frequency;
    assign m_playing   = res_reg.playing;

endmodule

// ===== sim/tone_table_sequencer_unit_tb.sv =====
// Self-checking testbench for the tone table sequencer: random and directed words, scoreboard.
module tone_table_sequencer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tts_pkg::*;

    localparam int          TONE_SLOTS   = 256;
    localparam int          TONE_SCALE   = 10;
    localparam int          IDLE_PCT     = 27;
    localparam int          HOLD_SPAN    = 150;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          REPORT_MAX   = 10;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam opcode_t     OP_UNUSED    = opcode_t'(2'd3);

    class tone_sequence_scoreboard;
        logic [INTERVAL_W-1:0] interval_us;
        logic [REPEAT_W-1:0]   repeat_limit;
        logic [LEN_W-1:0]      seq_len;
        bit                    running;
        logic [ACC_W-1:0]      elapsed_acc;
        logic [LEN_W-1:0]      position;
        logic [REPEAT_W-1:0]   pass_idx;
        logic [CODE_W-1:0]     tones [TONE_SLOTS];
        bit                    written [TONE_SLOTS];
        result_t               due_q [$];
        int unsigned           faults, words_seen, results_seen;
        int unsigned           tones_played, stops_sent, passes_done, settings_used;

        function new();
            interval_us  = INTERVAL_RESET;
            repeat_limit = REPEAT_RESET;
            seq_len      = LEN_RESET;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INTERVAL: interval_us  = data[INTERVAL_W-1:0];
                CFG_REPEAT:   repeat_limit = data[REPEAT_W-1:0];
                CFG_LENGTH:   seq_len      = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned span();
            return (seq_len > TONE_SLOTS) ? TONE_SLOTS : seq_len;
        endfunction

        // true when a tick of this length would fetch an entry never written
        function bit reads_blank(logic [ELAPSED_W-1:0] us);
            logic [ACC_W:0] sum;
            sum = {1'b0, elapsed_acc} + {{(ACC_W + 1 - ELAPSED_W){1'b0}}, us};
            if (!running || sum <= {{(ACC_W + 1 - INTERVAL_W){1'b0}}, interval_us})
                return 1'b0;
            return (position < span()) && !written[position[ADDR_W-1:0]];
        endfunction

        function result_t timer_step(logic [ELAPSED_W-1:0] us);
            result_t          r;
            logic [ACC_W:0]   sum;
            logic [CODE_W-1:0] code;
            r = '0;
            sum = {1'b0, elapsed_acc} + {{(ACC_W + 1 - ELAPSED_W){1'b0}}, us};
            elapsed_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
            if (elapsed_acc <= {{(ACC_W - INTERVAL_W){1'b0}}, interval_us})
                return r;
            if (position < span()) begin
                code = tones[position[ADDR_W-1:0]];
                if (code != 0) begin
                    r.action    = ACT_PLAY;
                    r.frequency = FREQ_W'(code * TONE_SCALE);
                    tones_played++;
                end else begin
                    r.action = ACT_STOP;
                    stops_sent++;
                end
                position++;
                elapsed_acc = '0;
            end else begin
                // end of pass: timer is kept
                r.action = ACT_STOP;
                stops_sent++;
                passes_done++;
                position = '0;
                if (int'(pass_idx) + 1 < int'(repeat_limit)) begin
                    pass_idx++;
                end else begin
                    running  = 1'b0;
                    pass_idx = '0;
                end
            end
            return r;
        endfunction

        function result_t predict(item_t w);
            result_t r;
            r = '0;
            case (w.opcode)
                OP_TICK:
                    if (running)
                        r = timer_step(w.elapsed_time);
                OP_PLAY: begin
                    running     = 1'b1;
                    elapsed_acc = '0;
                    position    = '0;
                    pass_idx    = '0;
                end
                OP_WRITE: begin
                    // address width covers the whole table, so no wrap is needed
                    tones[w.entry_address]   = w.entry_value;
                    written[w.entry_address] = 1'b1;
                end
                default: ;
            endcase
            r.playing = running;
            return r;
        endfunction

        function void note_word(item_t w);
            words_seen++;
            due_q.push_back(predict(w));
        endfunction

        // reported fields are action/frequency/playing
        function void check_result(logic [ACTION_W-1:0] act, logic [FREQ_W-1:0] fq,
                                   logic play);
            result_t want;
            results_seen++;
            if (due_q.size() == 0) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("ERROR: word %0d unexpected, got %0d/%0d/%0b",
                             results_seen, act, fq, play);
                return;
            end
            want = due_q.pop_front();
            if (want.action !== act || want.frequency !== fq || want.playing !== play) begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("ERROR: word %0d expected %0d/%0d/%0b got %0d/%0d/%0b",
                             results_seen, want.action, want.frequency, want.playing,
                             act, fq, play);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [OPCODE_W-1:0]   s_opcode;
    logic [ELAPSED_W-1:0]  s_elapsed_time;
    logic [ADDR_W-1:0]     s_entry_address;
    logic [CODE_W-1:0]     s_entry_value;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ACTION_W-1:0]   m_action;
    logic [FREQ_W-1:0]     m_frequency;
    logic                  m_playing;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    logic                  steady = 1'b0;
    logic                  flood = 1'b0;
    logic                  hold_done = 1'b0;
    int unsigned           hold_cycles = 0;
    int unsigned           cycles = 0;

    tone_sequence_scoreboard sb;

    tone_table_sequencer_unit #(.TABLE_DEPTH(TONE_SLOTS)) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_elapsed_time  (s_elapsed_time),
        .s_entry_address (s_entry_address),
        .s_entry_value   (s_entry_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_action        (m_action),
        .m_frequency     (m_frequency),
        .m_playing       (m_playing),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("TIMEOUT after %0d cycles", cycles);
            $display("tone_table_sequencer_unit: mismatch");
            $finish;
        end
    end

    // result side: random backpressure, one long hold while the sender floods
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result(m_action, m_frequency, m_playing);
            if (hold_cycles != 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready     <= 1'b0;
            end else if (flood && !hold_done) begin
                hold_cycles <= HOLD_SPAN;
                hold_done   <= 1'b1;
                m_ready     <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic item_t mk(opcode_t op, int unsigned us, int unsigned addr,
                                 int unsigned val);
        item_t w;
        w.opcode        = op;
        w.elapsed_time  = ELAPSED_W'(us);
        w.entry_address = ADDR_W'(addr);
        w.entry_value   = CODE_W'(val);
        return w;
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int unsigned top;
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return ELAPSED_W'($urandom);
            default: begin
                // land near the interval so both sides of the compare get hit
                top = sb.interval_us + sb.interval_us / 2 + 2;
                if (top > 65535)
                    top = 65535;
                return ELAPSED_W'($urandom_range(top, 0));
            end
        endcase
    endfunction

    function automatic item_t make_word();
        item_t       w;
        int unsigned roll;
        w = mk(OP_TICK, pick_elapsed(), $urandom, $urandom);
        roll = $urandom_range(99);
        if (sb.running)
            w.opcode = (roll < 80) ? OP_TICK : (roll < 91) ? OP_WRITE :
                       (roll < 95) ? OP_PLAY : OP_UNUSED;
        else
            w.opcode = (roll < 45) ? OP_PLAY : (roll < 75) ? OP_WRITE :
                       (roll < 92) ? OP_TICK : OP_UNUSED;
        // fill the entry about to be fetched instead of reading a blank one
        if (w.opcode == OP_TICK && sb.reads_blank(w.elapsed_time)) begin
            w.opcode        = OP_WRITE;
            w.entry_address = sb.position[ADDR_W-1:0];
        end
        return w;
    endfunction

    task automatic send_word(item_t w);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_opcode        <= w.opcode;
        s_elapsed_time  <= w.elapsed_time;
        s_entry_address <= w.entry_address;
        s_entry_value   <= w.entry_value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_word(w);
    endtask

    task automatic wait_drained();
        while (sb.due_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, int unsigned data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= CFG_DATA_W'(data);
        @(posedge aclk);
        sb.set_reg(idx, CFG_DATA_W'(data));
    endtask

    task automatic run_phase(int unsigned iv, int unsigned rp, int unsigned ln,
                             int unsigned words, bit steady_run, bit drain_mid);
        s_valid <= 1'b0;
        wait_drained();
        write_reg(CFG_INTERVAL, iv);
        write_reg(CFG_REPEAT, rp);
        write_reg(CFG_LENGTH, ln);
        cfg_wr_en <= 1'b0;
        sb.settings_used++;
        steady <= steady_run;
        flood  <= steady_run;
        for (int unsigned i = 0; i < words; i++) begin
            if (drain_mid && i == words / 2) begin
                s_valid <= 1'b0;
                wait_drained();
            end
            send_word(make_word());
        end
        steady <= 1'b0;
    endtask

    initial begin
        sb              = new();
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_opcode        = '0;
        s_elapsed_time  = '0;
        s_entry_address = '0;
        s_entry_value   = '0;
        cfg_wr_en       = 1'b0;
        cfg_addr        = '0;
        cfg_wr_data     = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed words under the reset settings
        send_word(mk(OP_WRITE, 0, 0, 255));
        send_word(mk(OP_WRITE, 0, 1, 0));
        send_word(mk(OP_WRITE, 0, 2, 1));
        send_word(mk(OP_WRITE, 65535, 255, 128));
        send_word(mk(OP_WRITE, 0, 3, 25));
        send_word(mk(OP_UNUSED, 65535, 255, 255));
        send_word(mk(OP_TICK, 65535, 0, 0));
        send_word(mk(OP_PLAY, 0, 0, 0));
        send_word(mk(OP_TICK, 0, 0, 0));
        send_word(mk(OP_TICK, 10000, 0, 0));
        send_word(mk(OP_TICK, 1, 0, 0));
        send_word(mk(OP_TICK, 65535, 0, 0));
        send_word(mk(OP_WRITE, 0, 4, 7));
        send_word(mk(OP_TICK, 10001, 0, 0));
        send_word(mk(OP_PLAY, 0, 0, 0));
        send_word(mk(OP_TICK, 65535, 0, 0));
        send_word(mk(OP_UNUSED, 0, 0, 0));
        send_word(mk(OP_TICK, 12345, 0, 0));
        sb.settings_used++;

        run_phase(0, 255, 0, 60, 1'b0, 1'b0);
        run_phase(5, 3, 4, 130, 1'b1, 1'b0);
        run_phase(24'hFFFFFF, 2, 3, 60, 1'b0, 1'b0);
        run_phase(100, 0, 8, 100, 1'b0, 1'b1);
        run_phase(1000, 4, 511, 120, 1'b0, 1'b0);
        run_phase(50, 255, 256, 100, 1'b0, 1'b0);
        run_phase($urandom_range(3000, 0), $urandom_range(6, 0), $urandom_range(40, 0),
                  100, 1'b0, 1'b0);

        s_valid <= 1'b0;
        wait_drained();
        sb.faults += sb.due_q.size();

        $display("Covered %0d words over %0d register settings, %0d results checked",
                 sb.words_seen, sb.settings_used, sb.results_seen);
        $display("Sequencer emitted %0d tones, %0d stops and ended %0d passes; %0d errors",
                 sb.tones_played, sb.stops_sent, sb.passes_done, sb.faults);
        if (sb.faults == 0)
            $display("tone_table_sequencer_unit: match");
        else
            $display("tone_table_sequencer_unit: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tts_pkg.sv
rtl/tts_table.sv
rtl/tts_ctrl.sv
rtl/tone_table_sequencer_unit.sv
sim/tone_table_sequencer_unit_tb.sv
